// File: hdl/binary_delta_patch_applier_macros.svh
// Assertion macros used by the checker file.
`ifndef BINARY_DELTA_PATCH_APPLIER_MACROS_SVH
`define BINARY_DELTA_PATCH_APPLIER_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define BDPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdpa assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define BDPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdpa assertion failed");

`endif

// File: hdl/bdpa_pkg.sv
`timescale 1ns / 1ps

package bdpa_pkg;

  localparam int OLD_DEPTH_DEF = 65536;
  localparam int OUTQ_DEPTH    = 3;
  localparam logic [31:0] SEEK_SIGN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CTRL  = 2'd1,
    ACT_PATCH = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CORRUPT    = 2'd1,
    ST_UNEXPECTED = 2'd2
  } status_t;

  // register select values, decoded on paddr[2]
  localparam logic REG_OLD_SIZE = 1'b0;
  localparam logic REG_NEW_SIZE = 1'b1;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_out;
    logic [31:0] byte_offset;
    status_t     status;
    logic        done_res;
  } res_t;

endpackage

// File: hdl/bdpa_patch_if.sv
`timescale 1ns / 1ps

interface bdpa_patch_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] old_addr;
  logic [7:0]  byte_in;
  logic [31:0] add_len;
  logic [31:0] mov_len;
  logic [31:0] seek_word;

  modport source (output valid, action, old_addr, byte_in, add_len, mov_len, seek_word,
                  input ready);
  modport sink (input valid, action, old_addr, byte_in, add_len, mov_len, seek_word,
                output ready);
endinterface

// File: hdl/bdpa_result_if.sv
`timescale 1ns / 1ps

interface bdpa_result_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  byte_out;
  logic [31:0] byte_offset;
  logic [1:0]  status;
  logic        done_res;

  modport source (output valid, has_byte, byte_out, byte_offset, status, done_res,
                  input ready);
  modport sink (input valid, has_byte, byte_out, byte_offset, status, done_res,
                output ready);
endinterface

// File: hdl/bdpa_ram.sv
`timescale 1ns / 1ps

module bdpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bdpa_core.sv
`timescale 1ns / 1ps

module bdpa_core #(
  parameter int OLD_DEPTH = bdpa_pkg::OLD_DEPTH_DEF,
  localparam int AW = $clog2(OLD_DEPTH),
  localparam int QCW = $clog2(bdpa_pkg::OUTQ_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  bdpa_patch_if.sink         patch,
  input  logic [16:0]        old_size,
  input  logic [31:0]        new_size,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [7:0]         ram_rdata,
  input  logic [QCW-1:0]     q_count,
  output logic               push_valid,
  output bdpa_pkg::res_t     push_res
);

  logic [31:0] new_pos, new_pos_next;
  logic [31:0] old_pos, old_pos_next;
  logic [31:0] diff_left, diff_left_next;
  logic [31:0] extra_left, extra_left_next;
  logic [31:0] pending_seek, pending_seek_next;
  logic        corrupt_flag, corrupt_flag_next;

  logic           s1_valid, s1_valid_next;
  bdpa_pkg::res_t s1_res, s1_res_next;
  logic           s1_add, s1_add_next;

  logic        accept;
  logic [31:0] step;
  logic [33:0] sum_all;
  logic [32:0] pos_end;
  logic        in_range;
  logic        load_ok;
  bdpa_pkg::act_t act;

  // leave room in the queue for the item in stage 1 and the one taken now
  assign patch.ready = ((QCW+1)'(q_count) + (QCW+1)'(s1_valid))
                       < (QCW+1)'(bdpa_pkg::OUTQ_DEPTH);
  assign accept = patch.valid && patch.ready;
  assign act    = bdpa_pkg::act_t'(patch.action);

  assign step     = patch.seek_word[31] ? (bdpa_pkg::SEEK_SIGN - patch.seek_word)
                                        : patch.seek_word;
  assign sum_all  = 34'(new_pos) + 34'(patch.add_len) + 34'(patch.mov_len);
  assign pos_end  = 33'(new_pos) + 33'd1;
  assign in_range = (old_pos < 32'(old_size)) && (old_pos < 32'(OLD_DEPTH));
  assign load_ok  = 32'(patch.old_addr) < 32'(OLD_DEPTH);

  // Loads write and patch bytes read at the accepting edge, in item order, so
  // a read never overlaps a pending write.
  assign ram_waddr = AW'(patch.old_addr);
  assign ram_wdata = patch.byte_in;
  assign ram_raddr = AW'(old_pos);

  always_comb begin
    new_pos_next      = new_pos;
    old_pos_next      = old_pos;
    diff_left_next    = diff_left;
    extra_left_next   = extra_left;
    pending_seek_next = pending_seek;
    corrupt_flag_next = corrupt_flag;
    s1_valid_next     = 1'b0;
    s1_res_next       = '0;
    s1_add_next       = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    if (accept) begin
      unique case (act)
        bdpa_pkg::ACT_LOAD: begin
          ram_we = load_ok;
        end
        bdpa_pkg::ACT_CTRL: begin
          if (corrupt_flag) begin
            s1_valid_next      = 1'b1;
            s1_res_next.status = bdpa_pkg::ST_CORRUPT;
          end else if (diff_left != 32'd0 || extra_left != 32'd0) begin
            s1_valid_next      = 1'b1;
            s1_res_next.status = bdpa_pkg::ST_UNEXPECTED;
          end else if (sum_all > 34'(new_size)) begin
            corrupt_flag_next  = 1'b1;
            s1_valid_next      = 1'b1;
            s1_res_next.status = bdpa_pkg::ST_CORRUPT;
          end else begin
            diff_left_next    = patch.add_len;
            extra_left_next   = patch.mov_len;
            pending_seek_next = step;
            if (patch.add_len == 32'd0) begin
              old_pos_next = old_pos + step;
            end
          end
        end
        bdpa_pkg::ACT_PATCH: begin
          s1_valid_next = 1'b1;
          if (corrupt_flag) begin
            s1_res_next.status = bdpa_pkg::ST_CORRUPT;
          end else if (diff_left != 32'd0) begin
            s1_res_next.has_byte    = 1'b1;
            s1_res_next.byte_out    = patch.byte_in;
            s1_res_next.byte_offset = new_pos;
            s1_res_next.status      = bdpa_pkg::ST_OK;
            s1_res_next.done_res    = pos_end == 33'(new_size);
            s1_add_next             = in_range;
            ram_re                  = in_range;
            new_pos_next            = new_pos + 32'd1;
            diff_left_next          = diff_left - 32'd1;
            // apply the seek as the diff run closes
            old_pos_next = old_pos + 32'd1 + ((diff_left == 32'd1) ? pending_seek : 32'd0);
          end else if (extra_left != 32'd0) begin
            s1_res_next.has_byte    = 1'b1;
            s1_res_next.byte_out    = patch.byte_in;
            s1_res_next.byte_offset = new_pos;
            s1_res_next.status      = bdpa_pkg::ST_OK;
            s1_res_next.done_res    = pos_end == 33'(new_size);
            new_pos_next            = new_pos + 32'd1;
            extra_left_next         = extra_left - 32'd1;
          end else begin
            s1_res_next.status = bdpa_pkg::ST_UNEXPECTED;
          end
        end
        default: begin
          s1_valid_next      = 1'b1;
          s1_res_next.status = bdpa_pkg::ST_UNEXPECTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      new_pos      <= '0;
      old_pos      <= '0;
      diff_left    <= '0;
      extra_left   <= '0;
      pending_seek <= '0;
      corrupt_flag <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      new_pos      <= new_pos_next;
      old_pos      <= old_pos_next;
      diff_left    <= diff_left_next;
      extra_left   <= extra_left_next;
      pending_seek <= pending_seek_next;
      corrupt_flag <= corrupt_flag_next;
      s1_valid     <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_res <= s1_res_next;
    s1_add <= s1_add_next;
  end

  // stage 1 always drains into the queue; the old byte arrives this cycle
  always_comb begin
    push_valid = s1_valid;
    push_res   = s1_res;
    if (s1_add) begin
      push_res.byte_out = s1_res.byte_out + ram_rdata;
    end
  end

endmodule

// File: hdl/bdpa_outq.sv
`timescale 1ns / 1ps

module bdpa_outq #(
  localparam int DEPTH = bdpa_pkg::OUTQ_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  bdpa_pkg::res_t push_res,
  output logic [CW-1:0]  count,
  bdpa_result_if.source  result
);

  bdpa_pkg::res_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, wr_ptr_next;
  logic [PW-1:0]  rd_ptr, rd_ptr_next;
  logic [CW-1:0]  count_next;
  logic           pop;
  bdpa_pkg::res_t head;

  assign pop  = result.valid && result.ready;
  assign head = entries[rd_ptr];

  assign result.valid       = count != '0;
  assign result.has_byte    = head.has_byte;
  assign result.byte_out    = head.byte_out;
  assign result.byte_offset = head.byte_offset;
  assign result.status      = head.status;
  assign result.done_res    = head.done_res;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push_valid) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    end
    count_next = count + CW'(push_valid) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries[wr_ptr] <= push_res;
    end
  end

endmodule

// File: hdl/binary_delta_patch_applier.sv
`timescale 1ns / 1ps
// Channel   Role    Handshake     Payload
// patch     sink    valid/ready   action, old_addr, byte_in, add_len, mov_len, seek_word
// result    source  valid/ready   has_byte, byte_out, byte_offset, status, done_res
// apb       slave   psel/penable  old_size at 0x0, new_size at 0x4
//
// One item per cycle while patch.ready is high. A result passes first through the
// stage-1 register, where the old-store read completes, and then through the
// three-entry result queue. Loads and accepted controls give no result. Reset
// clears all run state and the queue; the old store is not cleared. patch.ready
// drops only while the result queue, counting the item in flight, is full.

module binary_delta_patch_applier #(
  parameter int OLD_DEPTH = bdpa_pkg::OLD_DEPTH_DEF,
  localparam int AW = $clog2(OLD_DEPTH),
  localparam int QCW = $clog2(bdpa_pkg::OUTQ_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  bdpa_patch_if.sink    patch,
  bdpa_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [16:0] old_size;
  logic [31:0] new_size;
  logic        cfg_wr;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic [QCW-1:0] q_count;
  logic           push_valid;
  bdpa_pkg::res_t push_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bdpa_pkg::REG_NEW_SIZE) ? new_size : 32'(old_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      old_size <= '0;
      new_size <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == bdpa_pkg::REG_NEW_SIZE) begin
        new_size <= pwdata;
      end else begin
        old_size <= pwdata[16:0];
      end
    end
  end

  bdpa_ram #(
    .WIDTH (8),
    .DEPTH (OLD_DEPTH)
  ) u_old_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bdpa_core #(
    .OLD_DEPTH (OLD_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .patch      (patch),
    .old_size   (old_size),
    .new_size   (new_size),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_res   (push_res)
  );

  bdpa_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_res   (push_res),
    .count      (q_count),
    .result     (result)
  );

endmodule

// File: hdl/bdpa_checker.sv
`timescale 1ns / 1ps
`include "binary_delta_patch_applier_macros.svh"

module bdpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        has_byte,
  input logic [7:0]  byte_out,
  input logic [31:0] byte_offset,
  input logic [1:0]  status,
  input logic        done_res
);

  // a stalled item holds
  `BDPA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(byte_out) && $stable(byte_offset) && $stable(status))
  // nothing comes out straight after reset
  `BDPA_ASSERT_NOW(a_res_quiet, $past(rst), !res_valid)
  // byte items are always ok
  `BDPA_ASSERT_NOW(a_byte_ok, res_valid && has_byte, status == bdpa_pkg::ST_OK)
  // status-only items carry an error and no payload
  `BDPA_ASSERT_NOW(a_err_bare, res_valid && !has_byte, status != bdpa_pkg::ST_OK && byte_out == 8'd0 && byte_offset == 32'd0 && !done_res)

endmodule

bind binary_delta_patch_applier bdpa_checker u_bdpa_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .has_byte    (result.has_byte),
  .byte_out    (result.byte_out),
  .byte_offset (result.byte_offset),
  .status      (result.status),
  .done_res    (result.done_res)
);
